// File: hdl/cursor_linked_list_engine_assert.svh
// Assertion macros for the cursor linked list engine.
`ifndef CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CLLE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/clle_pkg.sv
// Package with command, status, state and cell operation codes.
`timescale 1ns / 1ps
package clle_pkg;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

endpackage

// File: hdl/clle_cell.sv
// One list cell: holds the element at its position and one stage of the read chain.
`timescale 1ns / 1ps
module clle_cell
    import clle_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int DW    = 32,
    parameter int TW    = 7
)
(
    input  logic          clk,
    input  cell_op_t      op,
    input  logic [TW-1:0] target,
    input  logic [DW-1:0] wr_data,
    input  logic [DW-1:0] left_value,
    input  logic [DW-1:0] right_value,
    input  logic [DW-1:0] rd_in,
    output logic [DW-1:0] value_out,
    output logic [DW-1:0] rd_out
);

    localparam logic [TW-1:0] MY_INDEX = TW'(INDEX);

    logic [DW-1:0] value_reg;
    logic [DW-1:0] value_next;
    logic [DW-1:0] rd_reg;
    logic [DW-1:0] rd_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_INSERT:
            begin
                if (MY_INDEX > target)
                begin
                    value_next = left_value;
                end
                else if (MY_INDEX == target)
                begin
                    value_next = wr_data;
                end
            end
            CELL_DELETE:
            begin
                if (MY_INDEX >= target)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
        rd_next = (MY_INDEX == target) ? value_reg : rd_in;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        rd_reg    <= rd_next;
    end

    assign value_out = value_reg;
    assign rd_out    = rd_reg;

endmodule

// File: hdl/cursor_linked_list_engine.sv
// Top level of the cursor linked list engine: command control and the row of list cells.
//
//  channel   dir  fields (low bit up)                                   size
//  s_axis    in   command[1:0] position[7:2] write_value[8+:DW]          request
//  m_axis    out  status[1:0] read_value[2+:DW] list_length[2+DW+:6]     result
//
//  Insert and delete: the request passes the execute state and then the output state.
//  Get: the request passes the execute, walk and output states, the walk set by
//  the read chain that carries the selected element one cell per cycle.
//  One request is in flight at a time; the next is taken while a result waits.
//  Reset empties the list at once; cell contents need no clearing.
//  A stalled result holds in the output register; the next request waits in the output state.
`timescale 1ns / 1ps
module cursor_linked_list_engine
    import clle_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // command, position, write_value
    input  logic [((CMD_W+POS_W+DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // status, read_value, list_length
    output logic [((STATUS_W+DATA_WIDTH+LEN_W+7)/8)*8-1:0] m_axis_tdata
);

    `include "cursor_linked_list_engine_assert.svh"

    localparam int DW    = DATA_WIDTH;
    localparam int CAP   = SLOTS - 2;
    localparam int CW    = $clog2(SLOTS - 1);
    localparam int TW    = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int OUT_W = ((STATUS_W + DATA_WIDTH + LEN_W + 7) / 8) * 8;

    state_t             state_reg;
    state_t             state_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [DW-1:0]      wdata_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      walk_reg;
    logic [CW-1:0]      walk_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [OUT_W-1:0]   m_data_reg;
    logic [OUT_W-1:0]   m_data_next;

    cell_op_t           cell_op;
    logic [TW-1:0]      pos_ext;
    logic [TW-1:0]      count_ext;
    logic [TW-1:0]      target;
    logic               pos_ok;
    logic               ins_pos_ok;
    logic [DW-1:0]      rd_result;
    logic               accept;

    logic [DW-1:0]      cell_value [CAP];
    logic [DW-1:0]      cell_rd    [CAP];

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign pos_ext   = TW'(pos_reg);
    assign count_ext = TW'(count_reg);
    assign target    = pos_ext - TW'(1);
    assign pos_ok     = (pos_reg != '0) && (pos_ext <= count_ext);
    assign ins_pos_ok = (pos_reg != '0) && (pos_ext <= count_ext + TW'(1));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_axis_tdata[CMD_W-1:0];
            pos_reg   <= s_axis_tdata[CMD_W +: POS_W];
            wdata_reg <= s_axis_tdata[CMD_W+POS_W +: DW];
        end
        walk_reg   <= walk_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        walk_next    = walk_reg;
        status_next  = status_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        cell_op      = CELL_HOLD;
        rd_result    = ((cmd_reg == CMD_GET) && (status_reg == STATUS_OK)) ?
                       cell_rd[CAP-1] : '0;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next  = ST_OUT;
                status_next = STATUS_RANGE;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (ins_pos_ok)
                        begin
                            if (count_reg == CW'(CAP))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                cell_op     = CELL_INSERT;
                                count_next  = count_reg + CW'(1);
                                status_next = STATUS_OK;
                            end
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (pos_ok)
                        begin
                            cell_op     = CELL_DELETE;
                            count_next  = count_reg - CW'(1);
                            status_next = STATUS_OK;
                        end
                    end
                    CMD_GET:
                    begin
                        if (pos_ok)
                        begin
                            status_next = STATUS_OK;
                            walk_next   = CW'(CAP - 2);
                            state_next  = ST_WALK;
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_RANGE;
                    end
                endcase
            end
            ST_WALK:
            begin
                if (walk_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    walk_next = walk_reg - CW'(1);
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next  = OUT_W'({LEN_W'(count_reg), rd_result, status_reg});
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    generate
        for (genvar i = 0; i < CAP; i++)
        begin : g_cell
            logic [DW-1:0] left_value;
            logic [DW-1:0] right_value;
            logic [DW-1:0] rd_in;

            if (i == 0)
            begin : g_first
                assign left_value = wdata_reg;
                assign rd_in      = '0;
            end
            else
            begin : g_mid
                assign left_value = cell_value[i-1];
                assign rd_in      = cell_rd[i-1];
            end

            if (i == CAP - 1)
            begin : g_last
                assign right_value = cell_value[i];
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
            end

            clle_cell #(
                .INDEX (i),
                .DW    (DW),
                .TW    (TW)
            ) u_cell (
                .clk         (clk),
                .op          (cell_op),
                .target      (target),
                .wr_data     (wdata_reg),
                .left_value  (left_value),
                .right_value (right_value),
                .rd_in       (rd_in),
                .value_out   (cell_value[i]),
                .rd_out      (cell_rd[i])
            );
        end
    endgenerate

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `CLLE_ASSERT_IMPLY(a_count_cap, 1'b1, count_reg <= CW'(CAP), "element count above capacity")
    `CLLE_ASSERT_NEXT(a_count_step, state_reg == ST_EXEC, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1)) || (count_reg == $past(count_reg) - CW'(1)), "element count moved by more than one")
    `CLLE_ASSERT_IMPLY(a_result_from_out, $rose(m_axis_tvalid), $past(state_reg) == ST_OUT, "result raised outside the output state")
    `CLLE_ASSERT_NEXT(a_count_idle_hold, state_reg != ST_EXEC, count_reg == $past(count_reg), "element count changed outside execution")

endmodule
